@@ rtl/rgbhsl_pkg.sv @@
// Shared types and constants for the RGB to HSL converter.
`default_nettype none

package rgbhsl_pkg;

    localparam int CH_W  = 8;
    localparam int HUE_W = 9;
    localparam int FRC_W = 16;

    localparam int DIV_NW = 24;
    localparam int DIV_DW = 8;
    localparam int DIV_QW = 17;

    localparam int PIPE_DEPTH = DIV_QW + 4;

    localparam logic [23:0] LT_RECIP = 24'd8421505;
    localparam logic [8:0]  TURN_DEG = 9'd360;
    localparam logic [8:0]  SUM_MAX  = 9'd510;
    localparam logic [8:0]  CH_MAX   = 9'd255;
    localparam logic [15:0] ONE_Q15  = 16'd32768;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    typedef struct packed {
        logic [HUE_W-1:0] hue_degrees;
        logic [FRC_W-1:0] saturation;
        logic [FRC_W-1:0] lightness;
    } t_hsl;

endpackage

`default_nettype wire

@@ rtl/rgb_to_hsl_converter.sv @@
// Top level: pipelined RGB to HSL pixel converter.
// An accepted request passes stage 1, stage 2, the dividers and the output register.
// Throughput: one pixel per cycle; busy is never raised.
// Depth is set by the two 17-stage bit-per-cycle dividers for saturation and hue.
// Reset clears the valid pipeline only; no result strobes until a new request.
`default_nettype none

module rgb_to_hsl_converter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              start,
    input  wire rgbhsl_pkg::t_rgb  i_req,
    output logic                   busy,
    output logic                   o_valid,
    output rgbhsl_pkg::t_hsl       o_result
);

    localparam int QW    = rgbhsl_pkg::DIV_QW;
    localparam int DEPTH = rgbhsl_pkg::PIPE_DEPTH;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    logic [DEPTH-1:0] r_vld;

    // stage 1
    logic [7:0]        r_mx, r_mn, n_mx, n_mn;
    t_sector           r_sec, n_sec;
    logic signed [8:0] r_diff, n_diff;

    // stage 2
    logic [7:0]         s_delta;
    logic [8:0]         s_sum;
    logic [8:0]         s_alt;
    logic [8:0]         r_sum;
    logic [7:0]         r_delta;
    logic [7:0]         r_den, n_den;
    logic [15:0]        r_base, n_base;
    logic signed [15:0] r_d60;
    logic [16:0]        r_d360;
    logic               r_grey;

    // divider feed
    logic signed [17:0] s_t0, s_t1;
    logic [16:0]        s_hnum;
    logic [22:0]        s_ly;
    logic [46:0]        s_lprod;
    logic [15:0]        r_lt   [0:QW];
    logic               r_gdly [0:QW];
    logic [QW-1:0]      s_sat_q, s_hue_q;

    // output
    logic [17:0]        s_sat_r;
    logic [8:0]         s_q9;
    rgbhsl_pkg::t_hsl   n_res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[DEPTH-2:0], start};
        end
    end

    always_comb begin
        if (i_req.red >= i_req.green && i_req.red >= i_req.blue) begin
            n_sec  = SEC_RED;
            n_mx   = i_req.red;
            n_diff = $signed({1'b0, i_req.green}) - $signed({1'b0, i_req.blue});
        end else if (i_req.green >= i_req.blue) begin
            n_sec  = SEC_GREEN;
            n_mx   = i_req.green;
            n_diff = $signed({1'b0, i_req.blue}) - $signed({1'b0, i_req.red});
        end else begin
            n_sec  = SEC_BLUE;
            n_mx   = i_req.blue;
            n_diff = $signed({1'b0, i_req.red}) - $signed({1'b0, i_req.green});
        end
        n_mn = i_req.red;
        if (i_req.green < n_mn) begin
            n_mn = i_req.green;
        end
        if (i_req.blue < n_mn) begin
            n_mn = i_req.blue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mx   <= n_mx;
        r_mn   <= n_mn;
        r_sec  <= n_sec;
        r_diff <= n_diff;
    end

    always_comb begin
        s_delta = r_mx - r_mn;
        s_sum   = {1'b0, r_mx} + {1'b0, r_mn};
        s_alt   = rgbhsl_pkg::SUM_MAX - s_sum;
        n_den   = (s_sum <= rgbhsl_pkg::CH_MAX) ? s_sum[7:0] : s_alt[7:0];
        case (r_sec)
            SEC_RED:   n_base = '0;
            SEC_GREEN: n_base = 16'(s_delta) * 16'd120;
            SEC_BLUE:  n_base = 16'(s_delta) * 16'd240;
            default:   n_base = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_sum   <= s_sum;
        r_delta <= s_delta;
        r_den   <= n_den;
        r_base  <= n_base;
        r_d60   <= 16'(r_diff) * 16'sd60;
        r_d360  <= 17'(s_delta) * 17'(rgbhsl_pkg::TURN_DEG);
        r_grey  <= (s_delta == 8'd0);
    end

    always_comb begin
        s_t0 = $signed({2'b00, r_base}) + 18'(r_d60);
        s_t1 = (s_t0 < 0) ? (s_t0 + $signed({1'b0, r_d360})) : s_t0;
        s_hnum = (s_t1 < 0) ? '0 : s_t1[16:0];
        s_ly    = {r_sum, 14'b0} + 23'd127;
        s_lprod = 47'(s_ly) * 47'(rgbhsl_pkg::LT_RECIP);
    end

    rgbhsl_div u_sat_div (
        .i_clk (i_clk),
        .i_num ({r_delta, 16'b0}),
        .i_den (r_den),
        .o_quo (s_sat_q)
    );

    rgbhsl_div u_hue_div (
        .i_clk (i_clk),
        .i_num ({7'b0, s_hnum}),
        .i_den (r_delta),
        .o_quo (s_hue_q)
    );

    always_ff @(posedge i_clk) begin
        r_lt[0]   <= s_lprod[46:31];
        r_gdly[0] <= r_grey;
        for (int k = 0; k < QW; k++) begin
            r_lt[k+1]   <= r_lt[k];
            r_gdly[k+1] <= r_gdly[k];
        end
    end

    always_comb begin
        s_sat_r = 18'(s_sat_q) + 18'd1;
        s_q9    = s_hue_q[8:0];
        n_res.lightness = r_lt[QW];
        if (r_gdly[QW]) begin
            n_res.saturation  = '0;
            n_res.hue_degrees = '0;
        end else begin
            n_res.saturation  = s_sat_r[16:1];
            n_res.hue_degrees = (s_q9 >= rgbhsl_pkg::TURN_DEG) ?
                                (s_q9 - rgbhsl_pkg::TURN_DEG) : s_q9;
        end
    end

    always_ff @(posedge i_clk) begin
        o_result <= n_res;
    end

    assign o_valid = r_vld[DEPTH-1];

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.hue_degrees < rgbhsl_pkg::TURN_DEG)
        else $error("hue out of range");

    a_frac_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.saturation <= rgbhsl_pkg::ONE_Q15 &&
                     o_result.lightness <= rgbhsl_pkg::ONE_Q15))
        else $error("saturation or lightness above one");

    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.saturation == 16'd0) |-> o_result.hue_degrees == 9'd0)
        else $error("grey pixel with nonzero hue");

    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.lightness == 16'd0) |-> o_result.saturation == 16'd0)
        else $error("black pixel with nonzero saturation");

endmodule

`default_nettype wire

@@ rtl/rgbhsl_div.sv @@
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module rgbhsl_div (
    input  wire logic                             i_clk,
    input  wire logic [rgbhsl_pkg::DIV_NW-1:0]    i_num,
    input  wire logic [rgbhsl_pkg::DIV_DW-1:0]    i_den,
    output logic      [rgbhsl_pkg::DIV_QW-1:0]    o_quo
);

    localparam int NW = rgbhsl_pkg::DIV_NW;
    localparam int DW = rgbhsl_pkg::DIV_DW;
    localparam int QW = rgbhsl_pkg::DIV_QW;
    localparam int W  = (NW > DW + QW) ? NW : DW + QW;

    logic [NW-1:0] r_rem [0:QW];
    logic [DW-1:0] r_den [0:QW-1];
    logic [QW-1:0] r_quo [1:QW];

    always_ff @(posedge i_clk) begin
        r_rem[0] <= i_num;
        r_den[0] <= i_den;
    end

    for (genvar s = 0; s < QW; s++) begin : g_stage
        localparam int B = QW - 1 - s;

        logic [W-1:0]  s_sub;
        logic [W-1:0]  s_rem;
        logic [W-1:0]  s_dif;
        logic          s_take;
        logic [QW-1:0] s_qin;
        logic [QW-1:0] s_bit;

        always_comb begin
            s_sub  = (W)'(r_den[s]) << B;
            s_rem  = (W)'(r_rem[s]);
            s_dif  = s_rem - s_sub;
            s_take = (s_rem >= s_sub);
            s_bit  = s_take ? ((QW)'(1) << B) : '0;
        end

        if (s == 0) begin : g_first
            assign s_qin = '0;
        end else begin : g_rest
            assign s_qin = r_quo[s];
        end

        always_ff @(posedge i_clk) begin
            r_rem[s+1] <= s_take ? s_dif[NW-1:0] : r_rem[s];
            r_quo[s+1] <= s_qin | s_bit;
        end

        if (s + 1 < QW) begin : g_den
            always_ff @(posedge i_clk) begin
                r_den[s+1] <= r_den[s];
            end
        end
    end

    assign o_quo = r_quo[QW];

endmodule

`default_nettype wire
